/* src/smbf_pkg.sv */
// Shared types, constants and helpers for the SPI master burst FIFO controller.
// Depends on nothing; every other file but the two interfaces refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package smbf_pkg;

  localparam int FIFO_DEPTH    = 64;
  localparam int COUNT_BITS    = 24;
  localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
  localparam int LVL_BITS      = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_BITS      = LVL_BITS + 1;
  localparam int EXT_BITS      = LVL_BITS + 7;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = COUNT_BITS;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_START = 3'd1,
    OP_SHIFT = 3'd2,
    OP_POP   = 3'd3,
    OP_FLUSH = 3'd4
  } opcode_t;

  typedef enum logic [5:0] {
    CMD_NOP   = 6'b000001,
    CMD_PUSH  = 6'b000010,
    CMD_START = 6'b000100,
    CMD_SHIFT = 6'b001000,
    CMD_POP   = 6'b010000,
    CMD_FLUSH = 6'b100000
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_TX_OVF = 3'd1,
    ERR_RX_OVF = 3'd2,
    ERR_RX_UDR = 3'd3,
    ERR_TX_UDR = 3'd4
  } err_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TOTAL_BURSTS = 2'd0,
    REG_TX_BURSTS    = 2'd1,
    REG_DISCARD      = 2'd2,
    REG_DUMMY_BYTE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       mosi_valid;
    logic       mosi_from_mem;
    logic       rx_valid;
    logic [6:0] rx_count;
    logic [6:0] tx_count;
    logic       busy;
    logic       complete;
    err_t       error_code;
  } res_t;

  // (ptr + lvl) mod FIFO_DEPTH; the sum stays below twice the depth
  function automatic logic [PTR_BITS-1:0] wrap_add(input logic [PTR_BITS-1:0] ptr,
                                                   input logic [LVL_BITS-1:0] lvl);
    logic [SUM_BITS-1:0] sum;
    sum = SUM_BITS'(ptr) + SUM_BITS'(lvl);
    if (sum >= SUM_BITS'(FIFO_DEPTH)) begin
      sum = sum - SUM_BITS'(FIFO_DEPTH);
    end
    return sum[PTR_BITS-1:0];
  endfunction

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] ptr);
    logic [PTR_BITS-1:0] res;
    if (ptr == PTR_BITS'(FIFO_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

  // level as the 7-bit status field
  function automatic logic [6:0] count7(input logic [LVL_BITS-1:0] lvl);
    logic [EXT_BITS-1:0] ext;
    ext = EXT_BITS'(lvl);
    return ext[6:0];
  endfunction

endpackage

`default_nettype wire

/* src/smbf_in_if.sv */
// Command channel: valid/ready handshake with the command payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface smbf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] tx_data;
  logic [7:0] miso_byte;

  modport source (output valid, output opcode, output tx_data, output miso_byte,
                  input ready);
  modport sink   (input valid, input opcode, input tx_data, input miso_byte,
                  output ready);
endinterface

`default_nettype wire

/* src/smbf_out_if.sv */
// Result channel: valid/ready handshake with the status payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface smbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mosi_byte;
  logic       mosi_valid;
  logic [7:0] rx_byte;
  logic       rx_valid;
  logic [6:0] rx_count;
  logic [6:0] tx_count;
  logic       busy_res;
  logic       complete;
  logic [2:0] error_code;

  modport source (output valid, output mosi_byte, output mosi_valid, output rx_byte,
                  output rx_valid, output rx_count, output tx_count, output busy_res,
                  output complete, output error_code, input ready);
  modport sink   (input valid, input mosi_byte, input mosi_valid, input rx_byte,
                  input rx_valid, input rx_count, input tx_count, input busy_res,
                  input complete, input error_code, output ready);
endinterface

`default_nettype wire

/* src/smbf_front.sv */
// Front end: accepts command beats, classifies the opcode and queues the command.
// Depends on smbf_pkg and smbf_in_if.
`timescale 1ns / 1ps
`default_nettype none

module smbf_front (
  input  logic            clk,
  input  logic            rst_n,
  smbf_in_if.sink         in_ch,
  output logic            q_valid,
  output smbf_pkg::cmd_t  q_cmd,
  input  logic            q_pop
);

  smbf_pkg::cmd_t                      entry_r [smbf_pkg::QUEUE_DEPTH];
  logic [smbf_pkg::QPTR_BITS-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [smbf_pkg::QPTR_BITS-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [smbf_pkg::QCNT_BITS-1:0]      cnt_r, cnt_nxt;
  smbf_pkg::cmd_t                      cmd_in;
  logic                                push;

  assign in_ch.ready = (cnt_r != smbf_pkg::QCNT_BITS'(smbf_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid & in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_cmd       = entry_r[rd_ptr_r];

  // shift carries the received byte, everything else the transmit byte
  always_comb begin
    cmd_in.data = in_ch.tx_data;
    case (smbf_pkg::opcode_t'(in_ch.opcode))
      smbf_pkg::OP_PUSH:  cmd_in.kind = smbf_pkg::CMD_PUSH;
      smbf_pkg::OP_START: cmd_in.kind = smbf_pkg::CMD_START;
      smbf_pkg::OP_SHIFT: begin
        cmd_in.kind = smbf_pkg::CMD_SHIFT;
        cmd_in.data = in_ch.miso_byte;
      end
      smbf_pkg::OP_POP:   cmd_in.kind = smbf_pkg::CMD_POP;
      smbf_pkg::OP_FLUSH: cmd_in.kind = smbf_pkg::CMD_FLUSH;
      default:            cmd_in.kind = smbf_pkg::CMD_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == smbf_pkg::QPTR_BITS'(smbf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == smbf_pkg::QPTR_BITS'(smbf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

/* src/smbf_back.sv */
// Back end: executes queued commands against the transmit and receive FIFOs,
// the burst counter and the configuration registers; registers the result beat.
// Depends on smbf_pkg and smbf_out_if.
`timescale 1ns / 1ps
`default_nettype none

module smbf_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [smbf_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [smbf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                                q_valid,
  input  smbf_pkg::cmd_t                      q_cmd,
  output logic                                q_pop,
  smbf_out_if.source                          out_ch
);

  // configuration
  logic [smbf_pkg::COUNT_BITS-1:0] total_r;
  logic [smbf_pkg::COUNT_BITS-1:0] tx_bursts_r;
  logic                            discard_r;
  logic [7:0]                      dummy_r;

  // FIFO and transfer state
  logic [7:0]                      tx_mem [smbf_pkg::FIFO_DEPTH];
  logic [7:0]                      rx_mem [smbf_pkg::FIFO_DEPTH];
  logic [7:0]                      tx_rd_r;
  logic [7:0]                      rx_rd_r;
  logic [smbf_pkg::LVL_BITS-1:0]   tx_lvl_r, tx_lvl_nxt;
  logic [smbf_pkg::LVL_BITS-1:0]   rx_lvl_r, rx_lvl_nxt;
  logic [smbf_pkg::PTR_BITS-1:0]   tx_rp_r, tx_rp_nxt;
  logic [smbf_pkg::PTR_BITS-1:0]   rx_rp_r, rx_rp_nxt;
  logic [smbf_pkg::COUNT_BITS-1:0] idx_r, idx_nxt, idx_inc;
  logic                            running_r, running_nxt;
  logic                            done_r, done_nxt;

  // result register
  smbf_pkg::res_t                  o_r, res;
  logic                            o_valid_r, o_valid_nxt;

  logic                            fire;
  logic                            in_tx;
  logic                            tx_we, tx_re, rx_we, rx_re;
  logic [smbf_pkg::PTR_BITS-1:0]   tx_wr_addr, rx_wr_addr;

  assign fire       = q_valid & (~o_valid_r | out_ch.ready);
  assign q_pop      = fire;
  assign in_tx      = (idx_r < tx_bursts_r);
  assign idx_inc    = idx_r + 1'b1;
  assign tx_wr_addr = smbf_pkg::wrap_add(tx_rp_r, tx_lvl_r);
  assign rx_wr_addr = smbf_pkg::wrap_add(rx_rp_r, rx_lvl_r);

  always_comb begin
    tx_lvl_nxt  = tx_lvl_r;
    rx_lvl_nxt  = rx_lvl_r;
    tx_rp_nxt   = tx_rp_r;
    rx_rp_nxt   = rx_rp_r;
    idx_nxt     = idx_r;
    running_nxt = running_r;
    done_nxt    = done_r;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    res         = '0;
    res.error_code = smbf_pkg::ERR_NONE;
    if (fire) begin
      case (q_cmd.kind)
        smbf_pkg::CMD_PUSH: begin
          if (tx_lvl_r >= smbf_pkg::LVL_BITS'(smbf_pkg::FIFO_DEPTH)) begin
            res.error_code = smbf_pkg::ERR_TX_OVF;
          end else begin
            tx_we      = 1'b1;
            tx_lvl_nxt = tx_lvl_r + 1'b1;
          end
        end
        smbf_pkg::CMD_START: begin
          idx_nxt     = '0;
          running_nxt = (total_r != '0);
          done_nxt    = (total_r == '0);
        end
        smbf_pkg::CMD_SHIFT: begin
          if (running_r) begin
            res.mosi_valid = 1'b1;
            if (in_tx && (tx_lvl_r != '0)) begin
              tx_re             = 1'b1;
              res.mosi_from_mem = 1'b1;
              tx_rp_nxt         = smbf_pkg::ptr_inc(tx_rp_r);
              tx_lvl_nxt        = tx_lvl_r - 1'b1;
            end else begin
              res.mosi_byte = dummy_r;
              if (in_tx) begin
                res.error_code = smbf_pkg::ERR_TX_UDR;
              end
            end
            if (!(discard_r && in_tx)) begin
              if (rx_lvl_r >= smbf_pkg::LVL_BITS'(smbf_pkg::FIFO_DEPTH)) begin
                // transmit underrun wins over receive overflow
                if (res.error_code == smbf_pkg::ERR_NONE) begin
                  res.error_code = smbf_pkg::ERR_RX_OVF;
                end
              end else begin
                rx_we      = 1'b1;
                rx_lvl_nxt = rx_lvl_r + 1'b1;
              end
            end
            idx_nxt = idx_inc;
            if (idx_inc >= total_r) begin
              running_nxt = 1'b0;
              done_nxt    = 1'b1;
            end
          end
        end
        smbf_pkg::CMD_POP: begin
          if (rx_lvl_r == '0) begin
            res.error_code = smbf_pkg::ERR_RX_UDR;
          end else begin
            rx_re        = 1'b1;
            res.rx_valid = 1'b1;
            rx_rp_nxt    = smbf_pkg::ptr_inc(rx_rp_r);
            rx_lvl_nxt   = rx_lvl_r - 1'b1;
          end
        end
        smbf_pkg::CMD_FLUSH: begin
          rx_lvl_nxt = '0;
          rx_rp_nxt  = '0;
        end
        default: ;
      endcase
    end
    res.rx_count = smbf_pkg::count7(rx_lvl_nxt);
    res.tx_count = smbf_pkg::count7(tx_lvl_nxt);
    res.busy     = running_nxt;
    res.complete = done_nxt;
  end

  always_comb begin
    if (fire) begin
      o_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      o_valid_nxt = 1'b0;
    end else begin
      o_valid_nxt = o_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      tx_bursts_r <= '0;
      discard_r   <= 1'b0;
      dummy_r     <= '0;
    end else if (cfg_we) begin
      case (smbf_pkg::reg_idx_t'(cfg_idx))
        smbf_pkg::REG_TOTAL_BURSTS: total_r     <= cfg_wdata[smbf_pkg::COUNT_BITS-1:0];
        smbf_pkg::REG_TX_BURSTS:    tx_bursts_r <= cfg_wdata[smbf_pkg::COUNT_BITS-1:0];
        smbf_pkg::REG_DISCARD:      discard_r   <= cfg_wdata[0];
        smbf_pkg::REG_DUMMY_BYTE:   dummy_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_lvl_r  <= '0;
      rx_lvl_r  <= '0;
      tx_rp_r   <= '0;
      rx_rp_r   <= '0;
      idx_r     <= '0;
      running_r <= 1'b0;
      done_r    <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      tx_lvl_r  <= tx_lvl_nxt;
      rx_lvl_r  <= rx_lvl_nxt;
      tx_rp_r   <= tx_rp_nxt;
      rx_rp_r   <= rx_rp_nxt;
      idx_r     <= idx_nxt;
      running_r <= running_nxt;
      done_r    <= done_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_r <= res;
    end
  end

  // read data only moves when a new result loads, so it holds through a stall
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wr_addr] <= q_cmd.data;
    end
    if (tx_re) begin
      tx_rd_r <= tx_mem[tx_rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wr_addr] <= q_cmd.data;
    end
    if (rx_re) begin
      rx_rd_r <= rx_mem[rx_rp_r];
    end
  end

  assign out_ch.valid      = o_valid_r;
  assign out_ch.mosi_byte  = o_r.mosi_from_mem ? tx_rd_r : o_r.mosi_byte;
  assign out_ch.mosi_valid = o_r.mosi_valid;
  assign out_ch.rx_byte    = o_r.rx_valid ? rx_rd_r : 8'h00;
  assign out_ch.rx_valid   = o_r.rx_valid;
  assign out_ch.rx_count   = o_r.rx_count;
  assign out_ch.tx_count   = o_r.tx_count;
  assign out_ch.busy_res   = o_r.busy;
  assign out_ch.complete   = o_r.complete;
  assign out_ch.error_code = o_r.error_code;

`ifndef SYNTHESIS
  a_tx_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_lvl_r <= smbf_pkg::LVL_BITS'(smbf_pkg::FIFO_DEPTH))
    else $error("transmit level beyond FIFO depth");

  a_rx_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_lvl_r <= smbf_pkg::LVL_BITS'(smbf_pkg::FIFO_DEPTH))
    else $error("receive level beyond FIFO depth");

  a_run_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(running_r && done_r))
    else $error("transfer running and complete at once");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (q_cmd.kind == smbf_pkg::CMD_FLUSH)) |=> (rx_lvl_r == '0))
    else $error("flush left bytes in receive FIFO");

  a_pop_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_r.rx_valid) |-> (o_r.error_code == smbf_pkg::ERR_NONE))
    else $error("popped byte reported with an error");
`endif

endmodule

`default_nettype wire

/* src/spi_master_burst_fifo_controller.sv */
// Flow: an accepted command beat is queued in the front end; the back end executes it
// and registers its result beat, stalling while a loaded result is not yet taken.
// Throughput: one command per cycle while the result channel is ready, set by the execute
// stage with one write and one registered read port on each 64-byte FIFO memory.
// Reset: synchronous, active low; clears levels, pointers, burst state and the
// configuration registers; FIFO memories are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module spi_master_burst_fifo_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [smbf_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [smbf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  smbf_in_if.sink                             in_ch,
  smbf_out_if.source                          out_ch
);

  logic           q_valid;
  logic           q_pop;
  smbf_pkg::cmd_t q_cmd;

  smbf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  smbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

/* dv/spi_master_burst_fifo_controller_tb.sv */
// Self-checking testbench for spi_master_burst_fifo_controller: a directed table
// followed by random transfers, with every result beat checked against the table's
// expected status or a predictor. Depends on smbf_pkg, smbf_in_if, smbf_out_if and spi_master_burst_fifo_controller.
`timescale 1ns / 1ps

module spi_master_burst_fifo_controller_tb;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 82;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       mosi_valid;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [6:0] rx_count;
    logic [6:0] tx_count;
    logic       busy;
    logic       complete;
    smbf_pkg::err_t error_code;
  } status_t;

  typedef struct packed {
    bit         is_reg;
    logic [2:0] code;
    logic [23:0] arg;
    logic [7:0] miso;
    bit         typed;
    status_t    want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [smbf_pkg::CFG_IDX_BITS-1:0] cfg_idx;
  logic [smbf_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

  smbf_in_if  in_bus ();
  smbf_out_if out_bus ();

  spi_master_burst_fifo_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted controller state and register copies
  logic [7:0]  txf_mem [smbf_pkg::FIFO_DEPTH];
  logic [7:0]  rxf_mem [smbf_pkg::FIFO_DEPTH];
  int          txf_lvl = 0;
  int          rxf_lvl = 0;
  int          txf_rd = 0;
  int          rxf_rd = 0;
  logic [23:0] bursts_done = '0;
  bit          xfer_on = 1'b0;
  bit          xfer_done = 1'b0;
  logic [23:0] cfg_total = '0;
  logic [23:0] cfg_txb = '0;
  bit          cfg_discard = 1'b0;
  logic [7:0]  cfg_dummy = '0;

  status_t     status_q [$];
  step_t       script [$];
  int          n_fail = 0;
  int          n_items = 0;
  int unsigned n_cycles = 0;
  bit          calm = 1'b0;

  function automatic status_t exec_cmd(input logic [2:0] op, input logic [7:0] txd,
                                       input logic [7:0] miso);
    status_t s;
    bit in_tx;
    s = '0;
    case (op)
      smbf_pkg::OP_PUSH: begin
        if (txf_lvl >= smbf_pkg::FIFO_DEPTH) begin
          s.error_code = smbf_pkg::ERR_TX_OVF;
        end else begin
          txf_mem[smbf_pkg::PTR_BITS'((txf_rd + txf_lvl) % smbf_pkg::FIFO_DEPTH)] = txd;
          txf_lvl++;
        end
      end
      smbf_pkg::OP_START: begin
        xfer_done = 1'b0;
        bursts_done = '0;
        xfer_on = (cfg_total != 0);
        xfer_done = (cfg_total == 0);
      end
      smbf_pkg::OP_SHIFT: begin
        if (xfer_on) begin
          in_tx = (bursts_done < cfg_txb);
          s.mosi_valid = 1'b1;
          if (in_tx && txf_lvl > 0) begin
            s.mosi_byte = txf_mem[smbf_pkg::PTR_BITS'(txf_rd)];
            txf_rd = (txf_rd + 1) % smbf_pkg::FIFO_DEPTH;
            txf_lvl--;
          end else begin
            s.mosi_byte = cfg_dummy;
            if (in_tx) s.error_code = smbf_pkg::ERR_TX_UDR;
          end
          // drop the received byte inside the transmit period when serialized
          if (!(cfg_discard && in_tx)) begin
            if (rxf_lvl >= smbf_pkg::FIFO_DEPTH) begin
              if (s.error_code == smbf_pkg::ERR_NONE) s.error_code = smbf_pkg::ERR_RX_OVF;
            end else begin
              rxf_mem[smbf_pkg::PTR_BITS'((rxf_rd + rxf_lvl) % smbf_pkg::FIFO_DEPTH)] = miso;
              rxf_lvl++;
            end
          end
          bursts_done = bursts_done + 1'b1;
          if (bursts_done >= cfg_total) begin
            xfer_on = 1'b0;
            xfer_done = 1'b1;
          end
        end
      end
      smbf_pkg::OP_POP: begin
        if (rxf_lvl == 0) begin
          s.error_code = smbf_pkg::ERR_RX_UDR;
        end else begin
          s.rx_byte = rxf_mem[smbf_pkg::PTR_BITS'(rxf_rd)];
          s.rx_valid = 1'b1;
          rxf_rd = (rxf_rd + 1) % smbf_pkg::FIFO_DEPTH;
          rxf_lvl--;
        end
      end
      smbf_pkg::OP_FLUSH: begin
        rxf_lvl = 0;
        rxf_rd = 0;
      end
      default: ;
    endcase
    s.rx_count = 7'(rxf_lvl);
    s.tx_count = 7'(txf_lvl);
    s.busy = xfer_on;
    s.complete = xfer_done;
    return s;
  endfunction

  function automatic status_t st(input int mosi, input int mv, input int rxb, input int rv,
                                 input int rxc, input int txc, input int busy, input int cpl,
                                 input smbf_pkg::err_t err);
    status_t s;
    s = '{8'(mosi), 1'(mv), 8'(rxb), 1'(rv), 7'(rxc), 7'(txc), 1'(busy), 1'(cpl), err};
    return s;
  endfunction

  function automatic step_t cmd_row(input logic [2:0] op, input logic [7:0] txd,
                                    input logic [7:0] miso);
    step_t r;
    r = '0;
    r.code = op;
    r.arg = 24'(txd);
    r.miso = miso;
    return r;
  endfunction

  function automatic step_t chk_row(input logic [2:0] op, input logic [7:0] txd,
                                    input logic [7:0] miso, input status_t want);
    step_t r;
    r = cmd_row(op, txd, miso);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic step_t reg_row(input smbf_pkg::reg_idx_t idx, input logic [23:0] val);
    step_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.code = 3'(idx);
    r.arg = val;
    return r;
  endfunction

  // hold valid low until every expected beat has come back, then let the pipe settle
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input smbf_pkg::reg_idx_t idx, input logic [23:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      smbf_pkg::REG_TOTAL_BURSTS: cfg_total = val;
      smbf_pkg::REG_TX_BURSTS:    cfg_txb = val;
      smbf_pkg::REG_DISCARD:      cfg_discard = val[0];
      smbf_pkg::REG_DUMMY_BYTE:   cfg_dummy = val[7:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic issue(input logic [2:0] op, input logic [7:0] txd, input logic [7:0] miso,
                       input bit typed, input status_t want);
    status_t predicted;
    while (!calm && $urandom_range(99) < 28) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.opcode <= op;
    in_bus.tx_data <= txd;
    in_bus.miso_byte <= miso;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predicted = exec_cmd(op, txd, miso);
    status_q.push_back(typed ? want : predicted);
    n_items++;
  endtask

  task automatic rand_cmd(input logic [2:0] op);
    issue(op, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    out_bus.ready <= calm || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin : check_results
    status_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (status_q.size() == 0) begin
        $error("result beat with no command pending");
        n_fail++;
      end else begin
        want = status_q.pop_front();
        check_field("mosi_byte", want.mosi_byte, out_bus.mosi_byte);
        check_field("mosi_valid", 8'(want.mosi_valid), 8'(out_bus.mosi_valid));
        check_field("rx_byte", want.rx_byte, out_bus.rx_byte);
        check_field("rx_valid", 8'(want.rx_valid), 8'(out_bus.rx_valid));
        check_field("rx_count", 8'(want.rx_count), 8'(out_bus.rx_count));
        check_field("tx_count", 8'(want.tx_count), 8'(out_bus.tx_count));
        check_field("busy_res", 8'(want.busy), 8'(out_bus.busy_res));
        check_field("complete", 8'(want.complete), 8'(out_bus.complete));
        check_field("error_code", 8'(want.error_code), 8'(out_bus.error_code));
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int phase;
    int budget;
    int pick;
    int k;
    logic [23:0] total;
    logic [23:0] txb;
    logic [7:0] dummy;
    bit discard;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = smbf_pkg::REG_TOTAL_BURSTS;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.opcode = smbf_pkg::OP_PUSH;
    in_bus.tx_data = '0;
    in_bus.miso_byte = '0;

    // out of reset: empty FIFOs, idle, registers zero
    script.push_back(chk_row(smbf_pkg::OP_POP, 8'h00, 8'h00,
                             st(0, 0, 0, 0, 0, 0, 0, 0, smbf_pkg::ERR_RX_UDR)));
    script.push_back(chk_row(smbf_pkg::OP_SHIFT, 8'h00, 8'hFF,
                             st(0, 0, 0, 0, 0, 0, 0, 0, smbf_pkg::ERR_NONE)));
    script.push_back(chk_row(smbf_pkg::OP_START, 8'h00, 8'h00,
                             st(0, 0, 0, 0, 0, 0, 0, 1, smbf_pkg::ERR_NONE)));
    script.push_back(chk_row(OP_SPARE_HI, 8'hFF, 8'hFF,
                             st(0, 0, 0, 0, 0, 0, 0, 1, smbf_pkg::ERR_NONE)));
    script.push_back(chk_row(smbf_pkg::OP_PUSH, 8'hFF, 8'h00,
                             st(0, 0, 0, 0, 0, 1, 0, 1, smbf_pkg::ERR_NONE)));
    script.push_back(chk_row(smbf_pkg::OP_PUSH, 8'h00, 8'hFF,
                             st(0, 0, 0, 0, 0, 2, 0, 1, smbf_pkg::ERR_NONE)));
    script.push_back(reg_row(smbf_pkg::REG_TOTAL_BURSTS, 24'd4));
    script.push_back(reg_row(smbf_pkg::REG_TX_BURSTS, 24'd3));
    script.push_back(reg_row(smbf_pkg::REG_DISCARD, 24'd0));
    script.push_back(reg_row(smbf_pkg::REG_DUMMY_BYTE, 24'hA5));
    script.push_back(chk_row(smbf_pkg::OP_START, 8'h00, 8'h00,
                             st(0, 0, 0, 0, 0, 2, 1, 0, smbf_pkg::ERR_NONE)));
    script.push_back(chk_row(smbf_pkg::OP_SHIFT, 8'h00, 8'hFF,
                             st(8'hFF, 1, 0, 0, 1, 1, 1, 0, smbf_pkg::ERR_NONE)));
    script.push_back(chk_row(smbf_pkg::OP_SHIFT, 8'h00, 8'h00,
                             st(8'h00, 1, 0, 0, 2, 0, 1, 0, smbf_pkg::ERR_NONE)));
    // transmit FIFO runs dry inside the transmit period
    script.push_back(chk_row(smbf_pkg::OP_SHIFT, 8'h00, 8'h5A,
                             st(8'hA5, 1, 0, 0, 3, 0, 1, 0, smbf_pkg::ERR_TX_UDR)));
    // restart mid-transfer, then shrink total_bursts to the bursts already done
    script.push_back(cmd_row(smbf_pkg::OP_START, 8'h00, 8'h00));
    script.push_back(cmd_row(smbf_pkg::OP_SHIFT, 8'h00, 8'h3C));
    script.push_back(reg_row(smbf_pkg::REG_TOTAL_BURSTS, 24'd1));
    script.push_back(cmd_row(smbf_pkg::OP_SHIFT, 8'h00, 8'hC3));
    script.push_back(cmd_row(smbf_pkg::OP_POP, 8'h00, 8'h00));
    script.push_back(cmd_row(smbf_pkg::OP_POP, 8'h00, 8'h00));
    script.push_back(cmd_row(smbf_pkg::OP_FLUSH, 8'h00, 8'h00));
    // serialized transfer: received bytes dropped while transmitting
    script.push_back(reg_row(smbf_pkg::REG_DISCARD, 24'd1));
    script.push_back(reg_row(smbf_pkg::REG_TOTAL_BURSTS, 24'd3));
    script.push_back(reg_row(smbf_pkg::REG_TX_BURSTS, 24'd1));
    script.push_back(reg_row(smbf_pkg::REG_DUMMY_BYTE, 24'h00));
    script.push_back(cmd_row(smbf_pkg::OP_PUSH, 8'h81, 8'h00));
    script.push_back(cmd_row(smbf_pkg::OP_START, 8'h00, 8'h00));
    script.push_back(cmd_row(smbf_pkg::OP_SHIFT, 8'h00, 8'h77));
    script.push_back(cmd_row(smbf_pkg::OP_SHIFT, 8'h00, 8'hEE));
    script.push_back(cmd_row(smbf_pkg::OP_SHIFT, 8'h00, 8'h11));
    script.push_back(cmd_row(smbf_pkg::OP_POP, 8'h00, 8'h00));
    script.push_back(cmd_row(OP_SPARE_LO, 8'h00, 8'h00));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        write_reg(smbf_pkg::reg_idx_t'(script[i].code[smbf_pkg::CFG_IDX_BITS-1:0]),
                  script[i].arg);
      end else begin
        issue(script[i].code, script[i].arg[7:0], script[i].miso, script[i].typed,
              script[i].want);
      end
    end

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: begin
          total = 24'hFFFFFF; txb = 24'hFFFFFF; discard = 1'b0; dummy = 8'hFF;
        end
        1: begin
          total = 24'd1; txb = 24'd0; discard = 1'b1; dummy = 8'h00;
        end
        2: begin
          total = 24'd0; txb = 24'd5; discard = 1'($urandom_range(1));
          dummy = 8'($urandom_range(255));
        end
        default: begin
          total = $urandom_range(1) ? 24'($urandom_range(1, 20)) : 24'($urandom_range(64, 140));
          txb = 24'($urandom_range(0, int'(total) + 3));
          discard = 1'($urandom_range(1));
          dummy = 8'($urandom_range(255));
        end
      endcase
      // registers change mid-transfer too: the predicted transfer may still be running
      write_reg(smbf_pkg::REG_TOTAL_BURSTS, total);
      write_reg(smbf_pkg::REG_TX_BURSTS, txb);
      write_reg(smbf_pkg::REG_DISCARD, 24'(discard));
      write_reg(smbf_pkg::REG_DUMMY_BYTE, 24'(dummy));
      calm = (phase == 4);
      budget = n_items + PHASE_ITEMS;
      while (n_items < budget) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          k = $urandom_range(0, 6);
          repeat (k) rand_cmd(smbf_pkg::OP_PUSH);
          rand_cmd(smbf_pkg::OP_START);
          k = $urandom_range(0, 12);
          repeat (k) rand_cmd(smbf_pkg::OP_SHIFT);
          repeat ($urandom_range(0, k + 1)) rand_cmd(smbf_pkg::OP_POP);
        end else if (pick < 63) begin
          // long runs of pushes and shifts that can overfill both FIFOs
          repeat ($urandom_range(60, 68)) rand_cmd(smbf_pkg::OP_PUSH);
          rand_cmd(smbf_pkg::OP_START);
          repeat ($urandom_range(60, 72)) rand_cmd(smbf_pkg::OP_SHIFT);
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 10)) rand_cmd(smbf_pkg::OP_POP);
        end else if (pick < 87) begin
          rand_cmd(smbf_pkg::OP_FLUSH);
        end else begin
          repeat ($urandom_range(1, 4)) rand_cmd(3'($urandom_range(7)));
        end
      end
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* spi_master_burst_fifo_controller.f */
src/smbf_pkg.sv
src/smbf_in_if.sv
src/smbf_out_if.sv
src/smbf_front.sv
src/smbf_back.sv
src/spi_master_burst_fifo_controller.sv
dv/spi_master_burst_fifo_controller_tb.sv
